// ----- rtl/bep_pkg.sv -----
// ----------------------------------------------------------------------------
// bep_pkg: shared types and helpers of the edge profiler
// Sequencer state codes, counter limits and the saturating increment used by
// the execution and edge counters of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package bep_pkg;

	localparam int unsigned CNT_W = 32;
	localparam int unsigned ADDR_W = 32;
	localparam int unsigned IDX_W = 8;
	localparam int unsigned MOD_W = 8;
	localparam int unsigned SLOT_OUT_W = 4;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		S_CLR  = 5'b00001,
		S_IDLE = 5'b00010,
		S_META = 5'b00100,
		S_SRCH = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	// Saturating counter increment.
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/bep_ram.sv -----
// ----------------------------------------------------------------------------
// bep_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bep_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/block_edge_profiler.sv -----
// ----------------------------------------------------------------------------
// block_edge_profiler: basic-block execution and edge profiler
// Counts block executions and the predecessor and caller edges between
// consecutive blocks of one module, all held in on-chip memories.
// ----------------------------------------------------------------------------
// Usage. Each input item reports one executed basic block over the in_valid /
// in_ready channel; one result item per input leaves over out_valid /
// out_ready and carries the updated execution count and the edge updates.
// After reset the block clears its count and list-length memory, one entry a
// cycle over all NUM_BLOCKS entries, with in_ready held low; it then accepts items.
// An item is accepted, its count and list lengths are read, then each list
// that it updates is scanned at one entry a cycle until the scan resolves,
// and then the result is handed over. The single read port of each list
// memory sets the scan speed. One item is worked on at a time. The result
// sits in an output register: the next item is accepted while it waits, and
// the block only stalls at hand-over when the receiver still has not taken
// the previous result.
// ----------------------------------------------------------------------------
`default_nettype none

module block_edge_profiler #(
	parameter int unsigned NUM_BLOCKS = 256,
	parameter int unsigned LIST_SLOTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  block_index,
	input  wire logic [31:0] block_offset,
	input  wire logic [7:0]  module_id,
	input  wire logic        ends_in_call,
	input  wire logic [31:0] call_offset,

	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      exec_count_now,
	output logic             same_module,
	output logic [3:0]       pred_slot,
	output logic             pred_new,
	output logic [31:0]      pred_freq_now,
	output logic             pred_full,
	output logic [3:0]       caller_slot,
	output logic             caller_new,
	output logic [31:0]      caller_freq_now,
	output logic             caller_full
);

	localparam int unsigned CW  = bep_pkg::CNT_W;
	localparam int unsigned AW  = bep_pkg::ADDR_W;
	localparam int unsigned BW  = $clog2(NUM_BLOCKS);
	localparam int unsigned LW  = $clog2(LIST_SLOTS);          // list length
	localparam int unsigned SW  = $clog2(LIST_SLOTS + 1);      // scan slot
	localparam int unsigned ENT = NUM_BLOCKS * LIST_SLOTS;
	localparam int unsigned EW  = $clog2(ENT);
	localparam int unsigned MW  = CW + 2 * LW;
	localparam logic [LW-1:0] CAP = LW'(LIST_SLOTS - 1);

	bep_pkg::state_t state_q;

	logic [BW-1:0] clr_q;
	logic [BW-1:0] addr_q;
	logic          blk_ok_q;
	logic          same_q;
	logic [AW-1:0] key_q;
	logic [AW-1:0] site_q;
	logic          was_call_q;

	// Previous block.
	logic [AW-1:0] last_offset_q;
	logic [7:0]    last_module_q;
	logic          last_valid_q;
	logic          last_was_call_q;
	logic [AW-1:0] last_site_q;

	logic [CW-1:0] cnt_q;
	logic [LW-1:0] plen_q;
	logic [LW-1:0] clen_q;

	// List scan.
	logic          lst_q;
	logic [SW-1:0] next_s_q;
	logic          pend_q;
	logic [SW-1:0] rslot_q;

	logic [3:0]    ps_q, cs_q;
	logic          pn_q, cn_q, pf_q, cf_q;
	logic [CW-1:0] pq_q, cq_q;

	// Memories.
	logic          meta_we, meta_re;
	logic [BW-1:0] meta_waddr, meta_raddr;
	logic [MW-1:0] meta_wdata, meta_rdata;
	logic          pred_we, call_we, list_re;
	logic [EW-1:0] rd_entry, wr_entry;
	logic [2*AW-1:0]      pred_wdata, pred_rdata;
	logic [2*AW+CW-1:0]   call_wdata, call_rdata;

	logic          accept;
	logic [16:0]   blk_wide;
	logic          blk_ok;
	logic [LW-1:0] len_cur;
	logic [AW-1:0] rd_key;
	logic [CW-1:0] rd_cnt;
	logic          hit;
	logic          more;
	logic [SW-1:0] wr_slot;
	logic [CW-1:0] new_cnt;
	logic          take_out;
	logic [CW-1:0] meta_cnt;
	logic [LW-1:0] meta_plen, meta_clen;

	assign in_ready = (state_q == bep_pkg::S_IDLE);
	assign accept   = in_valid && in_ready;
	assign blk_wide = 17'(block_index);
	assign blk_ok   = (blk_wide < 17'(NUM_BLOCKS));

	assign {meta_cnt, meta_plen, meta_clen} = meta_rdata;

	// The scan compares the previous block's offset against the entry read in
	// the last cycle while the next entry is being fetched.
	assign len_cur = lst_q ? clen_q : plen_q;
	assign rd_key  = lst_q ? call_rdata[2*AW+CW-1 -: AW] : pred_rdata[2*AW-1 -: AW];
	assign rd_cnt  = lst_q ? call_rdata[CW-1:0] : pred_rdata[CW-1:0];
	assign hit     = (state_q == bep_pkg::S_SRCH) && pend_q && (rd_key == key_q);
	assign more    = (next_s_q <= SW'(len_cur));
	assign new_cnt = hit ? bep_pkg::sat_inc(rd_cnt) : CW'(1);
	assign wr_slot = hit ? rslot_q : SW'(len_cur) + 1'b1;

	assign rd_entry = EW'(32'(addr_q) * 32'(LIST_SLOTS) + 32'(next_s_q));
	assign wr_entry = EW'(32'(addr_q) * 32'(LIST_SLOTS) + 32'(wr_slot));

	// A list write happens in the cycle the scan resolves: on a hit, or on a
	// miss while the list still has room.
	always_comb begin
		pred_we = 1'b0;
		call_we = 1'b0;
		list_re = 1'b0;
		if (state_q == bep_pkg::S_SRCH) begin
			if (hit || (!more && (len_cur < CAP))) begin
				pred_we = !lst_q;
				call_we = lst_q;
			end else if (more) begin
				list_re = 1'b1;
			end
		end
	end

	assign pred_wdata = {key_q, new_cnt};
	// A hit keeps the call site that was stored when the entry was appended.
	assign call_wdata = {key_q, hit ? call_rdata[AW+CW-1 -: AW] : site_q, new_cnt};

	assign take_out   = (state_q == bep_pkg::S_DONE) && (!out_valid || out_ready);
	assign meta_we    = (state_q == bep_pkg::S_CLR) ||
	                    ((state_q == bep_pkg::S_DONE) && blk_ok_q);
	assign meta_waddr = (state_q == bep_pkg::S_CLR) ? clr_q : addr_q;
	assign meta_wdata = (state_q == bep_pkg::S_CLR) ? '0 : {cnt_q, plen_q, clen_q};
	assign meta_re    = accept;
	assign meta_raddr = BW'(blk_wide);

	bep_ram #(.WIDTH(MW), .DEPTH(NUM_BLOCKS)) u_meta (
		.clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
		.re(meta_re), .raddr(meta_raddr), .rdata(meta_rdata)
	);

	bep_ram #(.WIDTH(2*AW), .DEPTH(ENT)) u_pred (
		.clk(clk), .we(pred_we), .waddr(wr_entry), .wdata(pred_wdata),
		.re(list_re && !lst_q), .raddr(rd_entry), .rdata(pred_rdata)
	);

	bep_ram #(.WIDTH(2*AW+CW), .DEPTH(ENT)) u_call (
		.clk(clk), .we(call_we), .waddr(wr_entry), .wdata(call_wdata),
		.re(list_re && lst_q), .raddr(rd_entry), .rdata(call_rdata)
	);

	// Payload registers of the item in work.
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q     <= BW'(blk_wide);
			key_q      <= last_offset_q;
			site_q     <= last_site_q;
			was_call_q <= last_was_call_q;
			same_q     <= last_valid_q && (module_id == last_module_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= bep_pkg::S_CLR;
			clr_q           <= '0;
			blk_ok_q        <= 1'b0;
			last_offset_q   <= '0;
			last_module_q   <= '0;
			last_valid_q    <= 1'b0;
			last_was_call_q <= 1'b0;
			last_site_q     <= '0;
			cnt_q           <= '0;
			plen_q          <= '0;
			clen_q          <= '0;
			lst_q           <= 1'b0;
			next_s_q        <= '0;
			pend_q          <= 1'b0;
			rslot_q         <= '0;
			ps_q <= '0; pn_q <= 1'b0; pq_q <= '0; pf_q <= 1'b0;
			cs_q <= '0; cn_q <= 1'b0; cq_q <= '0; cf_q <= 1'b0;
		end else begin
			case (state_q)
				bep_pkg::S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BW'(NUM_BLOCKS - 1)) begin
						state_q <= bep_pkg::S_IDLE;
					end
				end
				bep_pkg::S_IDLE: begin
					if (accept) begin
						blk_ok_q        <= blk_ok;
						last_offset_q   <= block_offset;
						last_module_q   <= module_id;
						last_valid_q    <= 1'b1;
						last_was_call_q <= ends_in_call;
						last_site_q     <= call_offset;
						ps_q <= '0; pn_q <= 1'b0; pq_q <= '0; pf_q <= 1'b0;
						cs_q <= '0; cn_q <= 1'b0; cq_q <= '0; cf_q <= 1'b0;
						state_q <= bep_pkg::S_META;
					end
				end
				bep_pkg::S_META: begin
					cnt_q    <= blk_ok_q ? bep_pkg::sat_inc(meta_cnt) : '0;
					plen_q   <= meta_plen;
					clen_q   <= meta_clen;
					lst_q    <= 1'b0;
					next_s_q <= SW'(1);
					pend_q   <= 1'b0;
					state_q  <= (blk_ok_q && same_q) ? bep_pkg::S_SRCH : bep_pkg::S_DONE;
				end
				bep_pkg::S_SRCH: begin
					if (hit || !more) begin
						if (hit || (len_cur < CAP)) begin
							if (lst_q) begin
								cs_q <= 4'(wr_slot); cn_q <= !hit; cq_q <= new_cnt;
							end else begin
								ps_q <= 4'(wr_slot); pn_q <= !hit; pq_q <= new_cnt;
							end
							if (!hit) begin
								if (lst_q) clen_q <= len_cur + 1'b1;
								else plen_q <= len_cur + 1'b1;
							end
						end else begin
							if (lst_q) cf_q <= 1'b1;
							else pf_q <= 1'b1;
						end
						// Move on to the caller list, or finish.
						pend_q   <= 1'b0;
						next_s_q <= SW'(1);
						if (!lst_q && was_call_q) begin
							lst_q <= 1'b1;
						end else begin
							state_q <= bep_pkg::S_DONE;
						end
					end else begin
						pend_q   <= 1'b1;
						rslot_q  <= next_s_q;
						next_s_q <= next_s_q + 1'b1;
					end
				end
				bep_pkg::S_DONE: begin
					if (take_out) begin
						state_q <= bep_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= bep_pkg::S_IDLE;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (take_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_out) begin
			exec_count_now  <= cnt_q;
			same_module     <= same_q;
			pred_slot       <= ps_q;
			pred_new        <= pn_q;
			pred_freq_now   <= pq_q;
			pred_full       <= pf_q;
			caller_slot     <= cs_q;
			caller_new      <= cn_q;
			caller_freq_now <= cq_q;
			caller_full     <= cf_q;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/bep_checker.sv -----
// ----------------------------------------------------------------------------
// bep_checker: port-level checks of the edge profiler
// Watches the result channel and the consistency of the reported edges.
// ----------------------------------------------------------------------------
`default_nettype none

module bep_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] exec_count_now,
	input wire logic        same_module,
	input wire logic [3:0]  pred_slot,
	input wire logic        pred_new,
	input wire logic [31:0] pred_freq_now,
	input wire logic        pred_full,
	input wire logic        caller_new,
	input wire logic [31:0] caller_freq_now,
	input wire logic        caller_full
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(exec_count_now))
		else $error("result item dropped or changed while stalled");

	a_new_edge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pred_new |-> pred_freq_now == 32'd1 && !pred_full)
		else $error("appended predecessor with wrong count");

	a_other_module: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !same_module |-> pred_slot == 4'd0 && !pred_new && !pred_full
			&& caller_freq_now == 32'd0 && !caller_new && !caller_full)
		else $error("edge reported across modules");

	a_caller_needs_pred: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (caller_new || caller_full) |-> same_module
			&& (pred_freq_now != 32'd0 || pred_full))
		else $error("caller edge without predecessor edge");

endmodule

bind block_edge_profiler bep_checker u_bep_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.exec_count_now(exec_count_now), .same_module(same_module),
	.pred_slot(pred_slot), .pred_new(pred_new), .pred_freq_now(pred_freq_now),
	.pred_full(pred_full), .caller_new(caller_new),
	.caller_freq_now(caller_freq_now), .caller_full(caller_full)
);

`default_nettype wire

// ----- sim/tb_block_edge_profiler.sv -----
// ----------------------------------------------------------------------------
// tb_block_edge_profiler: self-checking bench of the edge profiler
// Drives executed-block items through the input channel, predicts every
// result from a behavioural copy of the count and edge tables, and compares
// each result item field by field, with the sender, the receiver or both idling at random in some runs.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_block_edge_profiler;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned N_BLK = 256;
	localparam int unsigned N_SLOT = 16;
	localparam int unsigned LIST_CAP = N_SLOT - 1;

	// One predicted result item.
	typedef struct packed {
		logic [31:0] cnt;
		logic        same;
		logic [3:0]  pslot;
		logic        pnew;
		logic [31:0] pfreq;
		logic        pfull;
		logic [3:0]  cslot;
		logic        cnew;
		logic [31:0] cfreq;
		logic        cfull;
	} profile_t;

	// Idling modes of the run.
	typedef enum int {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] block_index;
	logic [31:0] block_offset;
	logic [7:0] module_id;
	logic ends_in_call;
	logic [31:0] call_offset;
	logic out_valid;
	logic out_ready;
	logic [31:0] exec_count_now;
	logic same_module;
	logic [3:0] pred_slot;
	logic pred_new;
	logic [31:0] pred_freq_now;
	logic pred_full;
	logic [3:0] caller_slot;
	logic caller_new;
	logic [31:0] caller_freq_now;
	logic caller_full;

	block_edge_profiler uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.block_index(block_index),
		.block_offset(block_offset),
		.module_id(module_id),
		.ends_in_call(ends_in_call),
		.call_offset(call_offset),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.exec_count_now(exec_count_now),
		.same_module(same_module),
		.pred_slot(pred_slot),
		.pred_new(pred_new),
		.pred_freq_now(pred_freq_now),
		.pred_full(pred_full),
		.caller_slot(caller_slot),
		.caller_new(caller_new),
		.caller_freq_now(caller_freq_now),
		.caller_full(caller_full)
	);

	// The shadow copy of the profile tables. List entries are kept in slots
	// 1 to LIST_CAP of each block, exactly as the block numbers them.
	logic [31:0] shadow_exec [N_BLK];
	int unsigned shadow_plen [N_BLK];
	logic [31:0] shadow_paddr [N_BLK][N_SLOT];
	logic [31:0] shadow_pcnt [N_BLK][N_SLOT];
	int unsigned shadow_clen [N_BLK];
	logic [31:0] shadow_caddr [N_BLK][N_SLOT];
	logic [31:0] shadow_csite [N_BLK][N_SLOT];
	logic [31:0] shadow_ccnt [N_BLK][N_SLOT];
	logic [31:0] prev_offset;
	logic [7:0] prev_module;
	logic prev_valid;
	logic prev_call;
	logic [31:0] prev_site;

	profile_t pending_profiles[$];
	int fail_count;
	idle_mode_t idle_mode;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [31:0] count_up(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic bit idle_now(input bit sender);
		if (idle_mode == IDLE_BOTH)
			return $urandom_range(99) < 9;
		if (sender && idle_mode == IDLE_SEND)
			return $urandom_range(99) < 60;
		if (!sender && idle_mode == IDLE_RECV)
			return $urandom_range(99) < 60;
		return 1'b0;
	endfunction

	// Works out the result of one executed block and updates the shadow tables.
	// Indexes are eight bits wide, so every block index lies inside the table.
	task automatic predict_profile(input logic [7:0] idx, input logic [31:0] offs,
			input logic [7:0] modn, input logic is_call, input logic [31:0] site);
		profile_t r;
		bit hit;
		int unsigned n;
		r = '0;
		r.same = prev_valid && (modn == prev_module);
		shadow_exec[idx] = count_up(shadow_exec[idx]);
		r.cnt = shadow_exec[idx];
		if (r.same) begin
			hit = 1'b0;
			n = shadow_plen[idx];
			for (int unsigned s = 1; s <= n && !hit; s++) begin
				if (shadow_paddr[idx][s] == prev_offset) begin
					hit = 1'b1;
					shadow_pcnt[idx][s] = count_up(shadow_pcnt[idx][s]);
					r.pslot = s[3:0];
					r.pfreq = shadow_pcnt[idx][s];
				end
			end
			if (!hit && n < LIST_CAP) begin
				n++;
				shadow_plen[idx] = n;
				shadow_paddr[idx][n] = prev_offset;
				shadow_pcnt[idx][n] = 32'd1;
				r.pslot = n[3:0];
				r.pnew = 1'b1;
				r.pfreq = 32'd1;
			end else if (!hit) begin
				r.pfull = 1'b1;
			end
			if (prev_call) begin
				hit = 1'b0;
				n = shadow_clen[idx];
				for (int unsigned s = 1; s <= n && !hit; s++) begin
					if (shadow_caddr[idx][s] == prev_offset) begin
						hit = 1'b1;
						shadow_ccnt[idx][s] = count_up(shadow_ccnt[idx][s]);
						r.cslot = s[3:0];
						r.cfreq = shadow_ccnt[idx][s];
					end
				end
				if (!hit && n < LIST_CAP) begin
					n++;
					shadow_clen[idx] = n;
					shadow_caddr[idx][n] = prev_offset;
					shadow_csite[idx][n] = prev_site;
					shadow_ccnt[idx][n] = 32'd1;
					r.cslot = n[3:0];
					r.cnew = 1'b1;
					r.cfreq = 32'd1;
				end else if (!hit) begin
					r.cfull = 1'b1;
				end
			end
		end
		prev_offset = offs;
		prev_module = modn;
		prev_valid = 1'b1;
		prev_call = is_call;
		prev_site = site;
		pending_profiles.push_back(r);
	endtask

	// Offers one item and holds it steady until in_ready is seen high. Valid only
	// drops while the sender idles between items.
	task automatic send_block(input logic [7:0] idx, input logic [31:0] offs,
			input logic [7:0] modn, input logic is_call, input logic [31:0] site);
		if (idle_now(1'b1)) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while (idle_now(1'b1))
				@(posedge clk);
		end
		in_valid <= 1'b1;
		block_index <= idx;
		block_offset <= offs;
		module_id <= modn;
		ends_in_call <= is_call;
		call_offset <= site;
		predict_profile(idx, offs, modn, is_call, site);
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	// Result checker: the receiver stalls at random in some phases and compares
	// each taken item with the oldest prediction.
	initial begin
		profile_t want;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_profiles.size() == 0) begin
					report_mismatch("result item with none expected", 32'd1, 32'd0);
				end else begin
					want = pending_profiles.pop_front();
					if (exec_count_now !== want.cnt)
						report_mismatch("exec_count_now", exec_count_now, want.cnt);
					if (same_module !== want.same)
						report_mismatch("same_module", same_module, want.same);
					if (pred_slot !== want.pslot)
						report_mismatch("pred_slot", pred_slot, want.pslot);
					if (pred_new !== want.pnew)
						report_mismatch("pred_new", pred_new, want.pnew);
					if (pred_freq_now !== want.pfreq)
						report_mismatch("pred_freq_now", pred_freq_now, want.pfreq);
					if (pred_full !== want.pfull)
						report_mismatch("pred_full", pred_full, want.pfull);
					if (caller_slot !== want.cslot)
						report_mismatch("caller_slot", caller_slot, want.cslot);
					if (caller_new !== want.cnew)
						report_mismatch("caller_new", caller_new, want.cnew);
					if (caller_freq_now !== want.cfreq)
						report_mismatch("caller_freq_now", caller_freq_now, want.cfreq);
					if (caller_full !== want.cfull)
						report_mismatch("caller_full", caller_full, want.cfull);
				end
			end
			out_ready <= !idle_now(1'b0);
		end
	end

	// Directed part: first event, module change, list fill to overflow, call
	// edges and the extremes of every field.
	task automatic test_directed();
		send_block(8'd0, 32'h0000_0000, 8'd0, 1'b1, 32'h0000_0000);
		send_block(8'd255, 32'hFFFF_FFFF, 8'd0, 1'b1, 32'hFFFF_FFFF);
		send_block(8'd0, 32'h1000, 8'd255, 1'b0, 32'h0);
		send_block(8'd0, 32'h1000, 8'd255, 1'b1, 32'hAAAA_5555);
		// Seventeen distinct predecessors into block 7 overflow its lists.
		for (int i = 0; i < 17; i++) begin
			send_block(8'd100 + i[7:0], 32'h2000 + i, 8'd9, 1'b1, 32'h5555_AAAA ^ i);
			send_block(8'd7, 32'h700, 8'd9, i[0], 32'h0);
		end
		// Repeat an edge that is already held so the hit path is taken.
		send_block(8'd100, 32'h2000, 8'd9, 1'b1, 32'h1234);
		send_block(8'd7, 32'h700, 8'd9, 1'b0, 32'h0);
	endtask

	// Random walks through a few modules and blocks, mostly repeating edges
	// so that lists fill and hits dominate, with some noise.
	task automatic test_random_walk(input int n_items);
		logic [31:0] offs;
		logic [7:0] idx;
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(9) == 0) begin
				idx = 8'($urandom);
				offs = $urandom;
				send_block(idx, offs, 8'($urandom), 1'($urandom), $urandom);
			end else begin
				idx = 8'($urandom_range(23));
				offs = {($urandom_range(3) == 0) ? 8'($urandom) : 8'h00, 24'h0}
					| (32'(idx) << 4);
				send_block(idx, offs, 8'($urandom_range(2)), 1'($urandom_range(1)),
					$urandom);
			end
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_profiles.size() != 0)
			@(posedge clk);
		repeat (50)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		block_index = '0;
		block_offset = '0;
		module_id = '0;
		ends_in_call = 1'b0;
		call_offset = '0;
		fail_count = 0;
		idle_mode = IDLE_NONE;
		prev_offset = '0;
		prev_module = '0;
		prev_valid = 1'b0;
		prev_call = 1'b0;
		prev_site = '0;
		for (int b = 0; b < N_BLK; b++) begin
			shadow_exec[b] = '0;
			shadow_plen[b] = 0;
			shadow_clen[b] = 0;
		end
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		idle_mode = IDLE_NONE;
		test_random_walk(300);
		idle_mode = IDLE_SEND;
		test_random_walk(300);
		idle_mode = IDLE_RECV;
		test_random_walk(300);
		idle_mode = IDLE_BOTH;
		test_random_walk(320);
		drain_results();
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog: well over the slowest run of about 1300 items, plus the table
	// clear after reset.
	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/bep_pkg.sv
rtl/bep_ram.sv
rtl/block_edge_profiler.sv
rtl/bep_checker.sv
sim/tb_block_edge_profiler.sv
